/* rtl/core/dvr_pkg.sv */
// Shared types and constants for the distance-vector route table.
// Used by dvr_cell and distance_vector_route_table; depends on nothing.
`default_nettype none

package dvr_pkg;

  localparam int DVR_TABLE_ENTRIES = 8;
  localparam int DVR_NODE_ID_BITS  = 4;

  localparam int DIST_W   = 8;
  localparam int TTL_W    = 8;
  localparam int ACTION_W = 4;
  localparam int TOUCH_W  = 4;

  localparam logic [DIST_W-1:0]  DIST_MAX  = 8'hFF;
  localparam logic [DIST_W-1:0]  DIST_ONE  = 8'd1;
  localparam logic [TOUCH_W-1:0] TOUCH_MAX = 4'hF;

  typedef enum logic [1:0] {
    KIND_ADVERT    = 2'd0,
    KIND_LINK_DOWN = 2'd1,
    KIND_LINK_UP   = 2'd2,
    KIND_PACKET    = 2'd3
  } kind_t;

  localparam logic [ACTION_W-1:0] ACT_UPDATED   = 4'd0;
  localparam logic [ACTION_W-1:0] ACT_INSERTED  = 4'd1;
  localparam logic [ACTION_W-1:0] ACT_UNCHANGED = 4'd2;
  localparam logic [ACTION_W-1:0] ACT_FULL      = 4'd3;
  localparam logic [ACTION_W-1:0] ACT_DELIVER   = 4'd4;
  localparam logic [ACTION_W-1:0] ACT_FORWARD   = 4'd5;
  localparam logic [ACTION_W-1:0] ACT_NO_ROUTE  = 4'd6;
  localparam logic [ACTION_W-1:0] ACT_TTL_EXP   = 4'd7;
  localparam logic [ACTION_W-1:0] ACT_LINK_DONE = 4'd8;

  // Control flags of the record that walks the cell chain.
  typedef struct packed {
    logic  valid;
    logic  pass;        // 0 lookup pass, 1 write-back pass
    kind_t kind;
    logic  adv_ok;
    logic  found;       // destination matched in some cell
    logic  free_found;  // a free slot was seen
    logic  sok;         // route-valid mark of the matched slot
    logic  wr_put;      // write-back: store full route at idx
    logic  wr_poison;   // write-back: clear route-valid mark at idx
  } dvr_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/dvr_cell.sv */
// One table slot of the route table plus one stage of the record chain.
// Depends on dvr_pkg.
`default_nettype none

module dvr_cell import dvr_pkg::*; #(
  parameter int NODE_ID_BITS = DVR_NODE_ID_BITS,
  parameter int IDX_W        = 3,
  parameter int CELL_IDX     = 0
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire dvr_ctl_t                ctl_i,
  input  wire logic [NODE_ID_BITS-1:0] peer_i,
  input  wire logic [NODE_ID_BITS-1:0] target_i,
  input  wire logic [DIST_W-1:0]       nd_i,
  input  wire logic [IDX_W-1:0]        idx_i,
  input  wire logic [IDX_W-1:0]        free_idx_i,
  input  wire logic [NODE_ID_BITS-1:0] hop_i,
  input  wire logic [DIST_W-1:0]       dist_i,
  input  wire logic [TOUCH_W-1:0]      touched_i,
  output dvr_ctl_t                     ctl_o,
  output logic [NODE_ID_BITS-1:0]      peer_o,
  output logic [NODE_ID_BITS-1:0]      target_o,
  output logic [DIST_W-1:0]            nd_o,
  output logic [IDX_W-1:0]             idx_o,
  output logic [IDX_W-1:0]             free_idx_o,
  output logic [NODE_ID_BITS-1:0]      hop_o,
  output logic [DIST_W-1:0]            dist_o,
  output logic [TOUCH_W-1:0]           touched_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  // slot state
  logic                    used_r, used_nxt;
  logic                    ok_r, ok_nxt;
  logic [NODE_ID_BITS-1:0] dest_r, dest_nxt;
  logic [NODE_ID_BITS-1:0] hop_r, hop_nxt;
  logic [DIST_W-1:0]       dist_r, dist_nxt;

  // record stage
  dvr_ctl_t                ctl_r, ctl_nxt;
  logic [NODE_ID_BITS-1:0] peer_r, target_r, hop_out_r, hop_out_nxt;
  logic [DIST_W-1:0]       nd_r, dist_out_r, dist_out_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt, free_r, free_nxt;
  logic [TOUCH_W-1:0]      touch_r, touch_nxt;

  logic hit_target;
  logic [TOUCH_W-1:0] touch_inc;

  assign hit_target = used_r && (dest_r == target_i);
  assign touch_inc  = (touched_i == TOUCH_MAX) ? TOUCH_MAX : touched_i + 1'b1;

  always_comb begin
    used_nxt     = used_r;
    ok_nxt       = ok_r;
    dest_nxt     = dest_r;
    hop_nxt      = hop_r;
    dist_nxt     = dist_r;
    ctl_nxt      = ctl_i;
    idx_nxt      = idx_i;
    free_nxt     = free_idx_i;
    hop_out_nxt  = hop_i;
    dist_out_nxt = dist_i;
    touch_nxt    = touched_i;
    if (ctl_i.valid && !ctl_i.pass) begin
      unique case (ctl_i.kind)
        KIND_ADVERT, KIND_PACKET: begin
          if (hit_target) begin
            ctl_nxt.found = 1'b1;
            ctl_nxt.sok   = ok_r;
            idx_nxt       = MY_IDX;
            hop_out_nxt   = hop_r;
            dist_out_nxt  = dist_r;
          end
          if (ctl_i.kind == KIND_ADVERT && !used_r && !ctl_i.free_found) begin
            ctl_nxt.free_found = 1'b1;
            free_nxt           = MY_IDX;
          end
        end
        KIND_LINK_DOWN: begin
          if (used_r && ok_r && hop_r == peer_i) begin
            ok_nxt    = 1'b0;
            touch_nxt = touch_inc;
          end
        end
        KIND_LINK_UP: begin
          if (used_r && dest_r == peer_i) begin
            hop_nxt   = peer_i;
            dist_nxt  = DIST_ONE;
            ok_nxt    = 1'b1;
            touch_nxt = touch_inc;
          end
        end
        default: begin
        end
      endcase
    end else if (ctl_i.valid && idx_i == MY_IDX) begin
      // write-back pass: store or poison the chosen slot
      if (ctl_i.wr_put) begin
        used_nxt = 1'b1;
        ok_nxt   = 1'b1;
        dest_nxt = target_i;
        hop_nxt  = peer_i;
        dist_nxt = nd_i;
      end else if (ctl_i.wr_poison) begin
        ok_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      ok_r   <= 1'b0;
      ctl_r  <= '0;
    end else begin
      used_r <= used_nxt;
      ok_r   <= ok_nxt;
      ctl_r  <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dest_r     <= dest_nxt;
    hop_r      <= hop_nxt;
    dist_r     <= dist_nxt;
    peer_r     <= peer_i;
    target_r   <= target_i;
    nd_r       <= nd_i;
    idx_r      <= idx_nxt;
    free_r     <= free_nxt;
    hop_out_r  <= hop_out_nxt;
    dist_out_r <= dist_out_nxt;
    touch_r    <= touch_nxt;
  end

  assign ctl_o      = ctl_r;
  assign peer_o     = peer_r;
  assign target_o   = target_r;
  assign nd_o       = nd_r;
  assign idx_o      = idx_r;
  assign free_idx_o = free_r;
  assign hop_o      = hop_out_r;
  assign dist_o     = dist_out_r;
  assign touched_o  = touch_r;

endmodule

`default_nettype wire

/* rtl/core/distance_vector_route_table.sv */
// Distance-vector route table: top level with the chain of slot cells.
// Busy blocks new items until the record has made both walks through the cell chain.
// Reset (rst_n low, synchronous): all slots free and invalid, own_id 0, chain empty.
// The result strobe lasts one cycle; the receiver cannot stall. Depends on dvr_pkg, dvr_cell.
`default_nettype none

module distance_vector_route_table import dvr_pkg::*; #(
  parameter int TABLE_ENTRIES = DVR_TABLE_ENTRIES,
  parameter int NODE_ID_BITS  = DVR_NODE_ID_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // configuration
  input  wire logic                    cfg_we,
  input  wire logic [NODE_ID_BITS-1:0] cfg_wdata,
  // input channel
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              in_kind,
  input  wire logic [NODE_ID_BITS-1:0] in_peer_id,
  input  wire logic [NODE_ID_BITS-1:0] in_target_id,
  input  wire logic [DIST_W-1:0]       in_adv_distance,
  input  wire logic                    in_adv_route_valid,
  input  wire logic [TTL_W-1:0]        in_packet_ttl,
  // result channel
  output logic                         out_valid,
  output logic [ACTION_W-1:0]          out_action,
  output logic [NODE_ID_BITS-1:0]      out_next_hop,
  output logic [TTL_W-1:0]             out_ttl_out,
  output logic [DIST_W-1:0]            out_route_distance,
  output logic [TOUCH_W-1:0]           out_entries_touched
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int LAST  = TABLE_ENTRIES - 1;

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  logic [NODE_ID_BITS-1:0] own_id_r;
  logic                    busy_r, busy_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [TTL_W-1:0]        ttl_r;
  logic                    accept;

  assign accept = start && !busy_r;

  // ---------------------------------------------------------------------------
  // Record chain: head feeds cell 0, cell g drives stage g.
  // A record makes a lookup pass, loops back once as a write-back pass,
  // and leaves the last cell as a finished result.
  // ---------------------------------------------------------------------------
  dvr_ctl_t                head_ctl;
  logic [NODE_ID_BITS-1:0] head_peer, head_target, head_hop;
  logic [DIST_W-1:0]       head_nd, head_dist;
  logic [IDX_W-1:0]        head_idx, head_free;
  logic [TOUCH_W-1:0]      head_touch;

  dvr_ctl_t                st_ctl    [TABLE_ENTRIES];
  logic [NODE_ID_BITS-1:0] st_peer   [TABLE_ENTRIES];
  logic [NODE_ID_BITS-1:0] st_target [TABLE_ENTRIES];
  logic [NODE_ID_BITS-1:0] st_hop    [TABLE_ENTRIES];
  logic [DIST_W-1:0]       st_nd     [TABLE_ENTRIES];
  logic [DIST_W-1:0]       st_dist   [TABLE_ENTRIES];
  logic [IDX_W-1:0]        st_idx    [TABLE_ENTRIES];
  logic [IDX_W-1:0]        st_free   [TABLE_ENTRIES];
  logic [TOUCH_W-1:0]      st_touch  [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] chain_vld;

  genvar g;
  generate
    for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_head
        dvr_cell #(
          .NODE_ID_BITS (NODE_ID_BITS),
          .IDX_W        (IDX_W),
          .CELL_IDX     (g)
        ) u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .ctl_i      (head_ctl),
          .peer_i     (head_peer),
          .target_i   (head_target),
          .nd_i       (head_nd),
          .idx_i      (head_idx),
          .free_idx_i (head_free),
          .hop_i      (head_hop),
          .dist_i     (head_dist),
          .touched_i  (head_touch),
          .ctl_o      (st_ctl[g]),
          .peer_o     (st_peer[g]),
          .target_o   (st_target[g]),
          .nd_o       (st_nd[g]),
          .idx_o      (st_idx[g]),
          .free_idx_o (st_free[g]),
          .hop_o      (st_hop[g]),
          .dist_o     (st_dist[g]),
          .touched_o  (st_touch[g])
        );
      end else begin : g_body
        dvr_cell #(
          .NODE_ID_BITS (NODE_ID_BITS),
          .IDX_W        (IDX_W),
          .CELL_IDX     (g)
        ) u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .ctl_i      (st_ctl[g-1]),
          .peer_i     (st_peer[g-1]),
          .target_i   (st_target[g-1]),
          .nd_i       (st_nd[g-1]),
          .idx_i      (st_idx[g-1]),
          .free_idx_i (st_free[g-1]),
          .hop_i      (st_hop[g-1]),
          .dist_i     (st_dist[g-1]),
          .touched_i  (st_touch[g-1]),
          .ctl_o      (st_ctl[g]),
          .peer_o     (st_peer[g]),
          .target_o   (st_target[g]),
          .nd_o       (st_nd[g]),
          .idx_o      (st_idx[g]),
          .free_idx_o (st_free[g]),
          .hop_o      (st_hop[g]),
          .dist_o     (st_dist[g]),
          .touched_o  (st_touch[g])
        );
      end
      assign chain_vld[g] = st_ctl[g].valid;
    end
  endgenerate

  // ---------------------------------------------------------------------------
  // Decision at the end of the lookup pass. Everything the cells gathered
  // is in the record leaving the last cell.
  // ---------------------------------------------------------------------------
  dvr_ctl_t                tail;
  logic                    tail_lookup, tail_done;
  logic                    tail_own;
  logic                    dec_put, dec_poison;
  logic [IDX_W-1:0]        dec_idx;
  logic [ACTION_W-1:0]     dec_action;
  logic [NODE_ID_BITS-1:0] dec_hop;
  logic [TTL_W-1:0]        dec_ttl;
  logic [DIST_W-1:0]       dec_dist;
  logic [TOUCH_W-1:0]      dec_touch;

  assign tail        = st_ctl[LAST];
  assign tail_lookup = tail.valid && !tail.pass;
  assign tail_done   = tail.valid && tail.pass;
  assign tail_own    = (st_target[LAST] == own_id_r);

  always_comb begin
    dec_put    = 1'b0;
    dec_poison = 1'b0;
    dec_idx    = tail.found ? st_idx[LAST] : st_free[LAST];
    dec_action = ACT_UNCHANGED;
    dec_hop    = '0;
    dec_ttl    = '0;
    dec_dist   = '0;
    dec_touch  = '0;
    unique case (tail.kind)
      KIND_ADVERT: begin
        // adverts for this node are ignored
        if (!tail_own) begin
          if (tail.found) begin
            dec_dist = st_dist[LAST];
            if (!tail.adv_ok) begin
              // an invalid advert only poisons a route through its sender
              if (st_hop[LAST] == st_peer[LAST]) begin
                dec_poison = 1'b1;
                dec_action = ACT_UPDATED;
              end
            end else if (st_hop[LAST] == st_peer[LAST] || !tail.sok ||
                         st_dist[LAST] > st_nd[LAST]) begin
              dec_put    = 1'b1;
              dec_dist   = st_nd[LAST];
              dec_action = ACT_UPDATED;
            end
          end else if (tail.adv_ok) begin
            if (tail.free_found) begin
              dec_put    = 1'b1;
              dec_dist   = st_nd[LAST];
              dec_action = ACT_INSERTED;
            end else begin
              dec_action = ACT_FULL;
            end
          end
        end
      end
      KIND_LINK_DOWN: begin
        dec_action = ACT_LINK_DONE;
        dec_touch  = st_touch[LAST];
      end
      KIND_LINK_UP: begin
        dec_action = ACT_LINK_DONE;
        dec_touch  = st_touch[LAST];
        if (st_touch[LAST] != '0) begin
          dec_dist = DIST_ONE;
        end
      end
      KIND_PACKET: begin
        if (tail_own) begin
          dec_action = ACT_DELIVER;
          dec_ttl    = (ttl_r == '0) ? '0 : ttl_r - 1'b1;
        end else if (!tail.found || !tail.sok) begin
          dec_action = ACT_NO_ROUTE;
        end else if (ttl_r == '0) begin
          dec_action = ACT_TTL_EXP;
        end else begin
          dec_action = ACT_FORWARD;
          dec_hop    = st_hop[LAST];
          dec_ttl    = ttl_r - 1'b1;
          dec_dist   = st_dist[LAST];
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Head of the chain: a new transfer, or the looped-back record.
  // ---------------------------------------------------------------------------
  always_comb begin
    head_ctl    = '0;
    head_peer   = st_peer[LAST];
    head_target = st_target[LAST];
    head_nd     = st_nd[LAST];
    head_idx    = dec_idx;
    head_free   = st_free[LAST];
    head_hop    = st_hop[LAST];
    head_dist   = st_dist[LAST];
    head_touch  = st_touch[LAST];
    if (accept) begin
      head_ctl.valid  = 1'b1;
      head_ctl.kind   = kind_t'(in_kind);
      head_ctl.adv_ok = in_adv_route_valid;
      head_peer       = in_peer_id;
      head_target     = in_target_id;
      // saturate the advertised distance plus one hop
      head_nd         = (in_adv_distance == DIST_MAX) ? DIST_MAX : in_adv_distance + 1'b1;
      head_idx        = '0;
      head_free       = '0;
      head_hop        = '0;
      head_dist       = '0;
      head_touch      = '0;
    end else if (tail_lookup) begin
      // loop back for the write-back pass with the chosen slot in idx
      head_ctl           = tail;
      head_ctl.pass      = 1'b1;
      head_ctl.wr_put    = dec_put;
      head_ctl.wr_poison = dec_poison;
    end
  end

  // ---------------------------------------------------------------------------
  // Result holding registers: captured at loopback, shown with the strobe.
  // ---------------------------------------------------------------------------
  logic [ACTION_W-1:0]     res_action_r;
  logic [NODE_ID_BITS-1:0] res_hop_r;
  logic [TTL_W-1:0]        res_ttl_r;
  logic [DIST_W-1:0]       res_dist_r;
  logic [TOUCH_W-1:0]      res_touch_r;

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (tail_done) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = tail_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r    <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        own_id_r <= cfg_wdata;
      end
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ttl_r <= in_packet_ttl;
    end
    if (tail_lookup) begin
      res_action_r <= dec_action;
      res_hop_r    <= dec_hop;
      res_ttl_r    <= dec_ttl;
      res_dist_r   <= dec_dist;
      res_touch_r  <= dec_touch;
    end
  end

  assign busy                = busy_r;
  assign out_valid           = out_valid_r;
  assign out_action          = res_action_r;
  assign out_next_hop        = res_hop_r;
  assign out_ttl_out         = res_ttl_r;
  assign out_route_distance  = res_dist_r;
  assign out_entries_touched = res_touch_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_one_record : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(chain_vld) <= 1)
    else $error("more than one record in the cell chain");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transfer taken but block not busy");

  a_strobe_ends_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe without a finished item");

  a_strobe_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire

/* test/distance_vector_route_table_tb.sv */
// Self-checking testbench for distance_vector_route_table: directed and random
// adverts, link events and packets, checked against an in-bench table model.
// Depends on dvr_pkg and the distance_vector_route_table RTL only.
`timescale 1ns / 1ps

module distance_vector_route_table_tb;
  import dvr_pkg::*;

  localparam int ENTRIES     = DVR_TABLE_ENTRIES;
  localparam int ID_W        = DVR_NODE_ID_BITS;
  // One item occupies the cell chain for two walks.
  localparam int LATENCY     = 2 * ENTRIES + 1;
  localparam int DRAIN       = 2 * LATENCY;
  // Upper bound on a quiet stretch of a correct run: long gap + chain walk + settle.
  localparam int STALL_LIMIT = 1000;
  localparam int RAND_PHASES = 5;
  localparam int RAND_ITEMS  = 400;

  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   peer;
    logic [ID_W-1:0]   target;
    logic [DIST_W-1:0] adv_dist;
    logic              adv_ok;
    logic [TTL_W-1:0]  ttl;
  } route_item_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ID_W-1:0]     next_hop;
    logic [TTL_W-1:0]    ttl_out;
    logic [DIST_W-1:0]   route_dist;
    logic [TOUCH_W-1:0]  touched;
  } route_result_t;

  // One entry of the work list: either an own_id write or a table item.
  typedef struct packed {
    logic            is_cfg;
    logic [ID_W-1:0] cfg_val;
    route_item_t     item;
  } route_work_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                cfg_we             = 1'b0;
  logic [ID_W-1:0]     cfg_wdata          = '0;
  logic                start              = 1'b0;
  logic                busy;
  logic [1:0]          in_kind            = '0;
  logic [ID_W-1:0]     in_peer_id         = '0;
  logic [ID_W-1:0]     in_target_id       = '0;
  logic [DIST_W-1:0]   in_adv_distance    = '0;
  logic                in_adv_route_valid = 1'b0;
  logic [TTL_W-1:0]    in_packet_ttl      = '0;
  logic                out_valid;
  logic [ACTION_W-1:0] out_action;
  logic [ID_W-1:0]     out_next_hop;
  logic [TTL_W-1:0]    out_ttl_out;
  logic [DIST_W-1:0]   out_route_distance;
  logic [TOUCH_W-1:0]  out_entries_touched;

  distance_vector_route_table #(
    .TABLE_ENTRIES(ENTRIES),
    .NODE_ID_BITS (ID_W)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_peer_id         (in_peer_id),
    .in_target_id       (in_target_id),
    .in_adv_distance    (in_adv_distance),
    .in_adv_route_valid (in_adv_route_valid),
    .in_packet_ttl      (in_packet_ttl),
    .out_valid          (out_valid),
    .out_action         (out_action),
    .out_next_hop       (out_next_hop),
    .out_ttl_out        (out_ttl_out),
    .out_route_distance (out_route_distance),
    .out_entries_touched(out_entries_touched)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the route table and of the own_id register.
  logic              tbl_used [ENTRIES];
  logic [ID_W-1:0]   tbl_dest [ENTRIES];
  logic [ID_W-1:0]   tbl_hop  [ENTRIES];
  logic [DIST_W-1:0] tbl_dist [ENTRIES];
  logic              tbl_ok   [ENTRIES];
  logic [ID_W-1:0]   node_id;

  route_work_t   route_work_q[$];
  route_result_t route_results_due[$];
  route_item_t   cur_item;
  route_work_t   cur_work;

  int  gap_left    = 0;
  int  burst_left  = 0;
  int  settle      = 0;
  int  err_count   = 0;
  int  quiet_count = 0;
  bit  stalled     = 1'b0;

  // ---------------------------------------------------------------------------
  // Table model
  // ---------------------------------------------------------------------------

  // Lowest slot in use that holds destination d, or -1.
  function automatic int find_route(logic [ID_W-1:0] d);
    int hit;
    hit = -1;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (tbl_used[i] && tbl_dest[i] == d) hit = i;
    end
    return hit;
  endfunction

  function automatic void store_route(int s, logic [ID_W-1:0] d, logic [ID_W-1:0] hop,
                                      logic [DIST_W-1:0] hop_dist);
    tbl_used[s] = 1'b1;
    tbl_dest[s] = d;
    tbl_hop[s]  = hop;
    tbl_dist[s] = hop_dist;
    tbl_ok[s]   = 1'b1;
  endfunction

  // Apply one item to the shadow table and return the result it must produce.
  function automatic route_result_t predict_route(route_item_t it);
    route_result_t     res;
    logic [DIST_W-1:0] nd;
    int                s;
    int                free_slot;
    int                cnt;
    res        = '0;
    res.action = ACT_UNCHANGED;
    cnt        = 0;
    nd         = (it.adv_dist == DIST_MAX) ? DIST_MAX : it.adv_dist + 1'b1;
    case (it.kind)
      KIND_ADVERT: begin
        // An advert for this node itself never touches the table.
        if (it.target != node_id) begin
          s = find_route(it.target);
          if (s >= 0) begin
            res.route_dist = tbl_dist[s];
            if (!it.adv_ok) begin
              // Poison only a route that goes through the sender.
              if (tbl_hop[s] == it.peer) begin
                tbl_ok[s]  = 1'b0;
                res.action = ACT_UPDATED;
              end
            end else if (tbl_hop[s] == it.peer || !tbl_ok[s] || tbl_dist[s] > nd) begin
              store_route(s, it.target, it.peer, nd);
              res.route_dist = nd;
              res.action     = ACT_UPDATED;
            end
          end else if (it.adv_ok) begin
            free_slot = -1;
            for (int i = ENTRIES - 1; i >= 0; i--) begin
              if (!tbl_used[i]) free_slot = i;
            end
            if (free_slot >= 0) begin
              store_route(free_slot, it.target, it.peer, nd);
              res.route_dist = nd;
              res.action     = ACT_INSERTED;
            end else begin
              res.action = ACT_FULL;
            end
          end
        end
      end
      KIND_LINK_DOWN: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_used[i] && tbl_ok[i] && tbl_hop[i] == it.peer) begin
            tbl_ok[i] = 1'b0;
            cnt++;
          end
        end
        res.action = ACT_LINK_DONE;
      end
      KIND_LINK_UP: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_used[i] && tbl_dest[i] == it.peer) begin
            store_route(i, it.peer, it.peer, DIST_ONE);
            cnt++;
          end
        end
        if (cnt != 0) res.route_dist = DIST_ONE;
        res.action = ACT_LINK_DONE;
      end
      default: begin
        if (it.target == node_id) begin
          res.action  = ACT_DELIVER;
          res.ttl_out = (it.ttl != 0) ? it.ttl - 1'b1 : '0;
        end else begin
          s = find_route(it.target);
          if (s < 0 || !tbl_ok[s]) begin
            res.action = ACT_NO_ROUTE;
          end else if (it.ttl == 0) begin
            res.action = ACT_TTL_EXP;
          end else begin
            res.action     = ACT_FORWARD;
            res.next_hop   = tbl_hop[s];
            res.ttl_out    = it.ttl - 1'b1;
            res.route_dist = tbl_dist[s];
          end
        end
      end
    endcase
    res.touched = (cnt > TOUCH_MAX) ? TOUCH_MAX : cnt[TOUCH_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  task automatic add_cfg(input logic [ID_W-1:0] val);
    route_work_t w;
    w         = '0;
    w.is_cfg  = 1'b1;
    w.cfg_val = val;
    route_work_q.push_back(w);
  endtask

  task automatic add_item(input kind_t kind, input int peer, input int target,
                          input int adv_dist, input int adv_ok, input int ttl);
    route_work_t w;
    w                = '0;
    w.item.kind      = kind;
    w.item.peer      = peer[ID_W-1:0];
    w.item.target    = target[ID_W-1:0];
    w.item.adv_dist  = adv_dist[DIST_W-1:0];
    w.item.adv_ok    = adv_ok[0];
    w.item.ttl       = ttl[TTL_W-1:0];
    route_work_q.push_back(w);
  endtask

  // Weight toward adverts and packets, with distances and TTLs at the edges.
  task automatic add_random_item();
    kind_t kind;
    int    r;
    int    adv_len;
    int    ttl;
    r = $urandom_range(0, 99);
    if (r < 40)      kind = KIND_ADVERT;
    else if (r < 55) kind = KIND_LINK_DOWN;
    else if (r < 70) kind = KIND_LINK_UP;
    else             kind = KIND_PACKET;
    r = $urandom_range(0, 99);
    if (r < 15)      adv_len = 0;
    else if (r < 30) adv_len = 255;
    else if (r < 40) adv_len = 254;
    else if (r < 75) adv_len = $urandom_range(0, 15);
    else             adv_len = $urandom_range(0, 255);
    r = $urandom_range(0, 99);
    if (r < 12)      ttl = 0;
    else if (r < 24) ttl = 1;
    else if (r < 34) ttl = 255;
    else             ttl = $urandom_range(0, 255);
    add_item(kind, $urandom_range(0, (1 << ID_W) - 1), $urandom_range(0, (1 << ID_W) - 1),
             adv_len, int'($urandom_range(0, 99) < 80), ttl);
  endtask

  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 80);
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 20);
    return $urandom_range(21, 80);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present items from the work list, write own_id only when idle
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      node_id = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        tbl_used[i] = 1'b0;
        tbl_dest[i] = '0;
        tbl_hop[i]  = '0;
        tbl_dist[i] = '0;
        tbl_ok[i]   = 1'b0;
      end
      start  <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      // The register write lands at this edge; mirror it.
      if (cfg_we) node_id = cfg_wdata;
      // Record the prediction for a transfer at this edge.
      if (start && !busy) begin
        route_results_due.push_back(predict_route(cur_item));
        gap_left = pick_gap();
      end
      if (start && busy) begin
        // Hold the item until the block takes it.
        cfg_we <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        start  <= 1'b0;
        cfg_we <= 1'b0;
      end else if (route_work_q.size() != 0 && !route_work_q[0].is_cfg) begin
        cur_work            = route_work_q.pop_front();
        cur_item            = cur_work.item;
        start              <= 1'b1;
        cfg_we             <= 1'b0;
        in_kind            <= cur_item.kind;
        in_peer_id         <= cur_item.peer;
        in_target_id       <= cur_item.target;
        in_adv_distance    <= cur_item.adv_dist;
        in_adv_route_valid <= cur_item.adv_ok;
        in_packet_ttl      <= cur_item.ttl;
      end else if (route_work_q.size() != 0 && route_results_due.size() == 0 && !busy &&
                   !start && !cfg_we) begin
        // Drain the chain fully before touching own_id.
        start <= 1'b0;
        if (settle < LATENCY) begin
          settle++;
          cfg_we <= 1'b0;
        end else begin
          settle     = 0;
          cur_work   = route_work_q.pop_front();
          cfg_we    <= 1'b1;
          cfg_wdata <= cur_work.cfg_val;
        end
      end else begin
        start  <= 1'b0;
        cfg_we <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result strobe with the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    route_result_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (route_results_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual action %0d", $time,
                   out_action);
          err_count++;
        end else begin
          want = route_results_due.pop_front();
          check_field("action", int'(want.action), int'(out_action));
          check_field("next_hop", int'(want.next_hop), int'(out_next_hop));
          check_field("ttl_out", int'(want.ttl_out), int'(out_ttl_out));
          check_field("route_distance", int'(want.route_dist), int'(out_route_distance));
          check_field("entries_touched", int'(want.touched), int'(out_entries_touched));
        end
      end
      // Watchdog: count cycles in which no transfer of any kind happens.
      if ((start && !busy) || out_valid || cfg_we) quiet_count = 0;
      else quiet_count++;
      if (quiet_count >= STALL_LIMIT) stalled = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build the work list, release reset, wait for the end
  // ---------------------------------------------------------------------------
  initial begin
    // Directed part with own_id at its top value.
    add_cfg(ID_W'((1 << ID_W) - 1));
    add_item(KIND_PACKET, 0, 15, 0, 1, 0);      // deliver, TTL 0 stays 0
    add_item(KIND_PACKET, 0, 15, 0, 1, 255);    // deliver, TTL 255
    add_item(KIND_PACKET, 0, 3, 0, 1, 10);      // empty table: no route
    add_item(KIND_ADVERT, 1, 15, 4, 1, 0);      // advert for own node
    add_item(KIND_ADVERT, 1, 3, 0, 1, 0);       // insert at distance 1
    add_item(KIND_ADVERT, 2, 3, 255, 1, 0);     // longer via other hop
    add_item(KIND_ADVERT, 1, 3, 254, 1, 0);     // refresh via sender, reach max
    add_item(KIND_ADVERT, 2, 3, 5, 1, 0);       // shorter route takes over
    add_item(KIND_ADVERT, 1, 3, 9, 0, 0);       // invalid from a non-next-hop
    add_item(KIND_ADVERT, 2, 3, 9, 0, 0);       // poison via next hop
    add_item(KIND_PACKET, 0, 3, 0, 1, 10);      // invalid route: no route
    add_item(KIND_ADVERT, 4, 3, 200, 1, 0);     // invalid route taken over
    add_item(KIND_PACKET, 0, 3, 0, 1, 0);       // TTL expired
    add_item(KIND_PACKET, 0, 3, 0, 1, 1);       // forward, TTL drops to 0
    add_item(KIND_ADVERT, 7, 9, 3, 0, 0);       // invalid unknown: no insert
    add_item(KIND_ADVERT, 4, 0, 10, 1, 0);      // fill the table
    add_item(KIND_ADVERT, 5, 1, 0, 1, 0);
    add_item(KIND_ADVERT, 6, 2, 3, 1, 0);
    add_item(KIND_ADVERT, 4, 4, 0, 1, 0);
    add_item(KIND_ADVERT, 4, 5, 7, 1, 0);
    add_item(KIND_ADVERT, 0, 6, 255, 1, 0);
    add_item(KIND_ADVERT, 15, 7, 1, 1, 0);
    add_item(KIND_ADVERT, 3, 8, 2, 1, 0);       // table full
    add_item(KIND_LINK_DOWN, 4, 0, 0, 1, 0);    // several routes via 4 drop
    add_item(KIND_LINK_UP, 5, 0, 0, 1, 0);      // route to 5 at distance 1
    add_item(KIND_LINK_UP, 9, 0, 0, 1, 0);      // nothing stored for 9
    add_item(KIND_PACKET, 0, 5, 0, 1, 255);     // forward via 5
    // Random phases, each under its own own_id, extremes included.
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       add_cfg('0);
        2:       add_cfg(ID_W'((1 << ID_W) - 1));
        default: add_cfg(ID_W'($urandom_range(0, (1 << ID_W) - 1)));
      endcase
      repeat (RAND_ITEMS) add_random_item();
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (!stalled &&
           !(route_work_q.size() == 0 && route_results_due.size() == 0 && !start)) begin
      @(posedge clk);
    end
    if (!stalled) repeat (DRAIN) @(posedge clk);
    if (!stalled && err_count == 0 && route_results_due.size() == 0) begin
      $display("distance_vector_route_table test passed");
    end else begin
      $display("distance_vector_route_table test failed");
    end
    $finish;
  end

endmodule
